// File: design/vector3_arith_unit_top_macros.svh
// assertion macros for the three-component vector arithmetic unit
`ifndef VECTOR3_ARITH_UNIT_TOP_MACROS_SVH
`define VECTOR3_ARITH_UNIT_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define VAU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define VAU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/vau_pkg.sv
// shared types and constants of the vector arithmetic unit
`default_nettype none

package vau_pkg;

   typedef enum logic [3:0] {
      MODE_VADD  = 4'd0,
      MODE_SADD  = 4'd1,
      MODE_VSUB  = 4'd2,
      MODE_SSUB  = 4'd3,
      MODE_VMUL  = 4'd4,
      MODE_SMUL  = 4'd5,
      MODE_VDIV  = 4'd6,
      MODE_SDIV  = 4'd7,
      MODE_MAG   = 4'd8,
      MODE_NORM  = 4'd9,
      MODE_EQUAL = 4'd10
   } mode_type;

   localparam int unsigned LANES = 3;

   localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   // per-item information that rides along the divider
   typedef struct packed {
      logic [3:0]              mode;
      logic                    eq;
      logic [LANES-1:0][31:0]  r_pre;
      logic                    ovf_pre;
      logic [30:0]             len;
      logic                    len_ovf;
      logic [LANES-1:0]        a_neg;
      logic [LANES-1:0]        q_neg;
      logic [LANES-1:0]        dz;
   } side_type;

endpackage

`default_nettype wire

// File: design/vau_div_pipe.sv
// pipelined restoring divider, three lanes, one quotient bit per stage
`default_nettype none

module vau_div_pipe #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          adv,
   input  logic                                          in_valid,
   input  logic [vau_pkg::LANES-1:0][32+FRAC_BITS-1:0]   in_num,
   input  logic [vau_pkg::LANES-1:0][31:0]               in_den,
   input  vau_pkg::side_type                             in_side,
   output logic                                          out_valid,
   output logic [vau_pkg::LANES-1:0][32+FRAC_BITS-1:0]   out_quo,
   output vau_pkg::side_type                             out_side
);
   import vau_pkg::*;

   localparam int NW = 32 + FRAC_BITS;

   typedef struct packed {
      logic [LANES-1:0][31:0]   rem;
      logic [LANES-1:0][NW-1:0] nq;
      logic [LANES-1:0][31:0]   den;
      side_type                 side;
   } dv_type;

   dv_type         st_in [NW];
   dv_type         st_ff [NW];
   logic [NW-1:0]  valid_ff;
   logic [NW-1:0]  valid_in;

   // dividend bits leave the top of nq, quotient bits enter at the bottom
   function automatic dv_type div_step(input dv_type s);
      dv_type      r;
      logic [32:0] remx;
      logic [32:0] diff;
      logic        ge;
      r = s;
      for (int i = 0; i < LANES; i++) begin
         remx = {s.rem[i], s.nq[i][NW-1]};
         diff = remx - {1'b0, s.den[i]};
         ge   = (remx >= {1'b0, s.den[i]});
         r.rem[i] = ge ? diff[31:0] : remx[31:0];
         r.nq[i]  = {s.nq[i][NW-2:0], ge};
      end
      return r;
   endfunction

   always_comb begin
      st_in[0].rem  = '0;
      st_in[0].nq   = in_num;
      st_in[0].den  = in_den;
      st_in[0].side = in_side;
      for (int k = 1; k < NW; k++) begin
         st_in[k] = st_ff[k-1];
      end
   end

   assign valid_in = {valid_ff[NW-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NW; k++) begin
            st_ff[k] <= div_step(st_in[k]);
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_quo   = st_ff[NW-1].nq;
   assign out_side  = st_ff[NW-1].side;

endmodule

`default_nettype wire

// File: design/vector3_arith_unit_top.sv
// top level of the three-component fixed-point vector arithmetic unit
//
//  channel | ports        | direction | carries
//  --------+--------------+-----------+-----------------------------------------
//  request | req_*        | in        | mode, vectors a and b, scalar
//  result  | rsp_*        | out       | r_x/y/z, length, equal, overflow, div_zero
//
// one item enters per clock while req_ready is high; words are Q16.16 at FRAC_BITS = 16
// items pass stages a-c, the 32-stage square root, the (32 + FRAC_BITS)-stage divider
// every mode travels the same pipeline, so results leave in request order
// reset clears the valid bits only; data registers keep whatever they hold
// the whole pipeline holds only while a result waits in the output register
// and the last divider stage is full; an empty last stage lets everything move on
`default_nettype none

`include "vector3_arith_unit_top_macros.svh"

module vector3_arith_unit_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_mode,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic signed [31:0] req_scale,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_r_x,
   output logic signed [31:0] rsp_r_y,
   output logic signed [31:0] rsp_r_z,
   output logic [30:0]        rsp_length,
   output logic               rsp_equal,
   output logic               rsp_overflow,
   output logic               rsp_div_zero
);
   import vau_pkg::*;

   localparam int NW       = 32 + FRAC_BITS;
   localparam int SQ_STEPS = 32;

   localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
   localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

   // square-root stage contents; also the layout of stage c
   typedef struct packed {
      logic [32:0]             rem;
      logic [31:0]             root;
      logic [63:0]             sh;
      logic [LANES-1:0][31:0]  amag;
      logic [LANES-1:0][31:0]  omag;
      logic [LANES-1:0]        a_neg;
      logic [LANES-1:0]        o_neg;
      side_type                side;
   } sq_type;

   // pipeline advance: the output register can take a new result,
   // or the last divider stage is empty
   logic adv;
   logic out_load;

   // ---------------- stage a: registered request ----------------
   logic [LANES-1:0][31:0] in_a;
   logic [LANES-1:0][31:0] in_b;
   logic [LANES-1:0][31:0] in_o;

   logic                   a_valid_ff;
   logic [3:0]             a_mode_ff;
   logic                   a_eq_ff;
   logic [LANES-1:0][31:0] a_a_ff;
   logic [LANES-1:0][31:0] a_o_ff;

   always_comb begin
      in_a[0] = req_a_x;
      in_a[1] = req_a_y;
      in_a[2] = req_a_z;
      in_b[0] = req_b_x;
      in_b[1] = req_b_y;
      in_b[2] = req_b_z;
      for (int i = 0; i < LANES; i++) begin
         // magnitude modes square a; odd modes use the scalar
         if (req_mode == MODE_MAG || req_mode == MODE_NORM) begin
            in_o[i] = in_a[i];
         end else if (req_mode[0]) begin
            in_o[i] = req_scale;
         end else begin
            in_o[i] = in_b[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_mode_ff <= req_mode;
         a_eq_ff   <= (in_a == in_b);
         a_a_ff    <= in_a;
         a_o_ff    <= in_o;
      end
   end

   // ---------------- stage b: products and sums ----------------
   logic [LANES-1:0][63:0] b_prod_in;
   logic [LANES-1:0][32:0] b_as_in;

   logic                   b_valid_ff;
   logic [3:0]             b_mode_ff;
   logic                   b_eq_ff;
   logic [LANES-1:0][31:0] b_a_ff;
   logic [LANES-1:0][31:0] b_o_ff;
   logic [LANES-1:0][63:0] b_prod_ff;
   logic [LANES-1:0][32:0] b_as_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         // one 32x32 signed multiplier per lane, shared by multiply and squaring
         b_prod_in[i] = $signed(a_a_ff[i]) * $signed(a_o_ff[i]);
         // bit 1 of the mode picks subtract within the add/subtract group
         if (a_mode_ff[1]) begin
            b_as_in[i] = {a_a_ff[i][31], a_a_ff[i]} - {a_o_ff[i][31], a_o_ff[i]};
         end else begin
            b_as_in[i] = {a_a_ff[i][31], a_a_ff[i]} + {a_o_ff[i][31], a_o_ff[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_mode_ff <= a_mode_ff;
         b_eq_ff   <= a_eq_ff;
         b_a_ff    <= a_a_ff;
         b_o_ff    <= a_o_ff;
         b_prod_ff <= b_prod_in;
         b_as_ff   <= b_as_in;
      end
   end

   // ---------------- stage c: saturation, sum of squares ----------------
   // returns {saturated, value}
   function automatic logic [32:0] sat_word(input logic signed [63:0] v);
      logic [32:0] r;
      if (v > WIDE_MAX) begin
         r = {1'b1, SAT_MAX};
      end else if (v < WIDE_MIN) begin
         r = {1'b1, SAT_MIN};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   sq_type c_in;
   sq_type c_ff;
   logic   c_valid_ff;

   always_comb begin
      logic signed [63:0] mul_w;
      logic signed [63:0] as_w;
      logic [32:0]        as_s;
      logic [32:0]        mul_s;
      c_in           = '0;
      c_in.sh        = b_prod_ff[0] + b_prod_ff[1] + b_prod_ff[2];
      c_in.side.mode = b_mode_ff;
      c_in.side.eq   = b_eq_ff;
      for (int i = 0; i < LANES; i++) begin
         // shift of the full product rounds toward minus infinity
         mul_w = $signed(b_prod_ff[i]) >>> FRAC_BITS;
         as_w  = 64'($signed(b_as_ff[i]));
         as_s  = sat_word(as_w);
         mul_s = sat_word(mul_w);
         case (b_mode_ff) inside
            MODE_VADD, MODE_SADD, MODE_VSUB, MODE_SSUB: begin
               c_in.side.r_pre[i] = as_s[31:0];
               c_in.side.ovf_pre  = c_in.side.ovf_pre | as_s[32];
            end
            MODE_VMUL, MODE_SMUL: begin
               c_in.side.r_pre[i] = mul_s[31:0];
               c_in.side.ovf_pre  = c_in.side.ovf_pre | mul_s[32];
            end
            default: begin
               c_in.side.r_pre[i] = '0;
            end
         endcase
         c_in.amag[i]       = b_a_ff[i][31] ? 32'd0 - b_a_ff[i] : b_a_ff[i];
         c_in.omag[i]       = b_o_ff[i][31] ? 32'd0 - b_o_ff[i] : b_o_ff[i];
         c_in.a_neg[i]      = b_a_ff[i][31];
         c_in.o_neg[i]      = b_o_ff[i][31];
         c_in.side.a_neg[i] = b_a_ff[i][31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff <= c_in;
      end
   end

   // ---------------- square root: one result bit per stage ----------------
   function automatic sq_type sqrt_step(input sq_type s);
      sq_type      r;
      logic [34:0] remx;
      logic [34:0] trial;
      logic [34:0] diff;
      r     = s;
      remx  = {s.rem, s.sh[63:62]};
      trial = {1'b0, s.root, 2'b01};
      diff  = remx - trial;
      r.sh  = {s.sh[61:0], 2'b00};
      if (remx >= trial) begin
         r.rem  = diff[32:0];
         r.root = {s.root[30:0], 1'b1};
      end else begin
         r.rem  = remx[32:0];
         r.root = {s.root[30:0], 1'b0};
      end
      return r;
   endfunction

   sq_type              sq_in [SQ_STEPS];
   sq_type              sq_ff [SQ_STEPS];
   logic [SQ_STEPS-1:0] sq_valid_ff;
   logic [SQ_STEPS-1:0] sq_valid_in;

   always_comb begin
      sq_in[0] = c_ff;
      for (int k = 1; k < SQ_STEPS; k++) begin
         sq_in[k] = sq_ff[k-1];
      end
   end

   assign sq_valid_in = {sq_valid_ff[SQ_STEPS-2:0], c_valid_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= '0;
      end else if (adv) begin
         sq_valid_ff <= sq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < SQ_STEPS; k++) begin
            sq_ff[k] <= sqrt_step(sq_in[k]);
         end
      end
   end

   // ---------------- divider operands ----------------
   sq_type                 sq_last;
   logic [31:0]            mag;
   logic                   div_mode;
   side_type               dv_side_in;
   logic [LANES-1:0][NW-1:0] dv_num_in;
   logic [LANES-1:0][31:0] dv_den_in;

   assign sq_last  = sq_ff[SQ_STEPS-1];
   assign mag      = sq_last.root;
   assign div_mode = (sq_last.side.mode == MODE_VDIV) || (sq_last.side.mode == MODE_SDIV)
                  || (sq_last.side.mode == MODE_NORM);

   always_comb begin
      dv_side_in         = sq_last.side;
      dv_side_in.len     = mag[31] ? SAT_MAX[30:0] : mag[30:0];
      dv_side_in.len_ovf = mag[31];
      for (int i = 0; i < LANES; i++) begin
         // normalize divides by the unsaturated magnitude, which is never negative
         if (sq_last.side.mode == MODE_NORM) begin
            dv_den_in[i]        = mag;
            dv_side_in.q_neg[i] = sq_last.a_neg[i];
         end else begin
            dv_den_in[i]        = sq_last.omag[i];
            dv_side_in.q_neg[i] = sq_last.a_neg[i] ^ sq_last.o_neg[i];
         end
         dv_side_in.dz[i] = div_mode && (dv_den_in[i] == '0);
         dv_num_in[i]     = {sq_last.amag[i], {FRAC_BITS{1'b0}}};
      end
   end

   logic                     dv_valid;
   logic [LANES-1:0][NW-1:0] dv_quo;
   side_type                 dv_side;

   vau_div_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid_ff[SQ_STEPS-1]),
      .in_num    (dv_num_in),
      .in_den    (dv_den_in),
      .in_side   (dv_side_in),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // ---------------- result assembly and output register ----------------
   logic [LANES-1:0][31:0] fin_r;
   logic [30:0]            fin_len;
   logic                   fin_ovf;
   logic                   fin_dz;

   always_comb begin
      logic [LANES-1:0][31:0] dres;
      logic                   div_ovf;
      div_ovf = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         if (dv_side.dz[i]) begin
            // zero divisor: saturate by the sign of the dividend
            dres[i] = dv_side.a_neg[i] ? SAT_MIN : SAT_MAX;
         end else if (!dv_side.q_neg[i]) begin
            if (dv_quo[i] > NW'(SAT_MAX)) begin
               dres[i] = SAT_MAX;
               div_ovf = 1'b1;
            end else begin
               dres[i] = dv_quo[i][31:0];
            end
         end else begin
            if (dv_quo[i] > NW'(SAT_MIN)) begin
               dres[i] = SAT_MIN;
               div_ovf = 1'b1;
            end else begin
               dres[i] = 32'd0 - dv_quo[i][31:0];
            end
         end
      end

      fin_r   = '0;
      fin_len = '0;
      fin_ovf = 1'b0;
      fin_dz  = 1'b0;
      case (dv_side.mode) inside
         MODE_VADD, MODE_SADD, MODE_VSUB, MODE_SSUB, MODE_VMUL, MODE_SMUL: begin
            fin_r   = dv_side.r_pre;
            fin_ovf = dv_side.ovf_pre;
         end
         MODE_VDIV, MODE_SDIV: begin
            fin_r   = dres;
            fin_ovf = div_ovf;
            fin_dz  = |dv_side.dz;
         end
         MODE_MAG: begin
            fin_len = dv_side.len;
            fin_ovf = dv_side.len_ovf;
         end
         MODE_NORM: begin
            fin_r   = dres;
            fin_len = dv_side.len;
            fin_ovf = div_ovf | dv_side.len_ovf;
            fin_dz  = |dv_side.dz;
         end
         default: begin
            // equality test and unused codes carry only the equal flag
            fin_r = '0;
         end
      endcase
   end

   logic                   rsp_valid_ff;
   logic [LANES-1:0][31:0] rsp_r_ff;
   logic [30:0]            rsp_len_ff;
   logic                   rsp_eq_ff;
   logic                   rsp_ovf_ff;
   logic                   rsp_dz_ff;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign adv       = out_load || !dv_valid;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && dv_valid) begin
         rsp_r_ff   <= fin_r;
         rsp_len_ff <= fin_len;
         rsp_eq_ff  <= dv_side.eq;
         rsp_ovf_ff <= fin_ovf;
         rsp_dz_ff  <= fin_dz;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_r_x      = rsp_r_ff[0];
   assign rsp_r_y      = rsp_r_ff[1];
   assign rsp_r_z      = rsp_r_ff[2];
   assign rsp_length   = rsp_len_ff;
   assign rsp_equal    = rsp_eq_ff;
   assign rsp_overflow = rsp_ovf_ff;
   assign rsp_div_zero = rsp_dz_ff;

   // ---------------- assertions ----------------
   `VAU_ASSERT_NEXT(chk_accept_enters, req_valid && req_ready, a_valid_ff, "accepted transfer lost at entry")
   `VAU_ASSERT_NOW(chk_stall_full, !req_ready, rsp_valid && !rsp_ready && dv_valid, "pipeline stalled with room")
   `VAU_ASSERT_NOW(chk_dz_length, rsp_valid && rsp_div_zero, rsp_length == '0, "zero divisor with nonzero length")

endmodule

`default_nettype wire

// File: bench/tb_vector3_arith_unit_top.sv
// self-checking testbench of the three-component vector arithmetic unit
`default_nettype none

module tb_vector3_arith_unit_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vau_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int LATENCY = 68 + FRAC_BITS;
   localparam int N_RANDOM = 1900;
   localparam int STALL_LIMIT = 5000;
   localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

   // one request as it goes into the block
   typedef struct {
      logic [3:0]         mode;
      logic signed [31:0] a [3];
      logic signed [31:0] b [3];
      logic signed [31:0] scale;
   } vec_req_type;

   // one result as the block hands it out
   typedef struct {
      logic signed [31:0] r [3];
      logic [30:0]        length;
      logic               equal;
      logic               overflow;
      logic               div_zero;
   } vec_rsp_type;

   // directed row: request plus an optional typed-in answer
   typedef struct {
      vec_req_type req;
      bit          fixed;
      vec_rsp_type rsp;
   } vec_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [3:0]         req_mode = '0;
   logic signed [31:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [31:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic signed [31:0] req_scale = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_r_x, rsp_r_y, rsp_r_z;
   logic [30:0]        rsp_length;
   logic               rsp_equal, rsp_overflow, rsp_div_zero;

   vector3_arith_unit_top #(.FRAC_BITS(FRAC_BITS)) dut (.*);

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   vec_rsp_type expected_results [$];
   int          mismatches = 0;
   bit          stim_done = 1'b0;
   bit          hold_rsp = 1'b0;   // request of a long result stall
   int          idle_cycles = 0;

   // ---------------------------------------------------------------------------
   // arithmetic of the unit, 64-bit wide before saturation
   // ---------------------------------------------------------------------------
   function automatic logic signed [31:0] clamp32(longint v, inout bit ovf);
      if (v > longint'(S_MAX)) begin
         ovf = 1'b1;
         return S_MAX;
      end
      if (v < longint'(S_MIN)) begin
         ovf = 1'b1;
         return S_MIN;
      end
      return v[31:0];
   endfunction

   // product floored to the fraction width (arithmetic shift floors)
   function automatic logic signed [31:0] fix_mul(longint x, longint y, inout bit ovf);
      longint p;
      p = x * y;
      return clamp32(p >>> FRAC_BITS, ovf);
   endfunction

   // quotient truncated toward zero; a zero divisor saturates by dividend sign
   function automatic logic signed [31:0] fix_div(longint n, longint d,
                                                  inout bit ovf, inout bit dz);
      longint q;
      if (d == 0) begin
         dz = 1'b1;
         return (n >= 0) ? S_MAX : S_MIN;
      end
      q = (n <<< FRAC_BITS) / d;
      return clamp32(q, ovf);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic vec_rsp_type vector_result(vec_req_type q);
      vec_rsp_type     o;
      bit              ovf, dz;
      longint          opnd;
      longint unsigned sum, mag, m;
      ovf = 0;
      dz = 0;
      sum = 0;
      o.r = '{0, 0, 0};
      o.length = '0;
      o.equal = (q.a[0] == q.b[0]) && (q.a[1] == q.b[1]) && (q.a[2] == q.b[2]);
      if (q.mode <= MODE_SDIV) begin
         for (int i = 0; i < 3; i++) begin
            opnd = q.mode[0] ? longint'(q.scale) : longint'(q.b[i]);
            case (q.mode[3:1])
               3'd0: o.r[i] = clamp32(longint'(q.a[i]) + opnd, ovf);
               3'd1: o.r[i] = clamp32(longint'(q.a[i]) - opnd, ovf);
               3'd2: o.r[i] = fix_mul(q.a[i], opnd, ovf);
               default: o.r[i] = fix_div(q.a[i], opnd, ovf, dz);
            endcase
         end
      end else if (q.mode == MODE_MAG || q.mode == MODE_NORM) begin
         for (int i = 0; i < 3; i++) begin
            mag = (q.a[i] < 0) ? -longint'(q.a[i]) : longint'(q.a[i]);
            sum += mag * mag;
         end
         m = int_sqrt(sum);
         if (m > 64'h7fff_ffff) begin
            o.length = '1;
            ovf = 1'b1;
         end else begin
            o.length = m[30:0];
         end
         if (q.mode == MODE_NORM)
            for (int i = 0; i < 3; i++) o.r[i] = fix_div(q.a[i], longint'(m), ovf, dz);
      end
      o.overflow = ovf;
      o.div_zero = dz;
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // directed table
   // ---------------------------------------------------------------------------
   vec_row_type directed_rows [$];

   function automatic vec_req_type mk_req(logic [3:0] md, logic signed [31:0] ax,
         logic signed [31:0] ay, logic signed [31:0] az, logic signed [31:0] bx,
         logic signed [31:0] by, logic signed [31:0] bz, logic signed [31:0] sc);
      vec_req_type q;
      q.mode = md;
      q.a = '{ax, ay, az};
      q.b = '{bx, by, bz};
      q.scale = sc;
      return q;
   endfunction

   task automatic add_row(vec_req_type q);
      vec_row_type row;
      row.req = q;
      row.fixed = 1'b0;
      directed_rows.push_back(row);
   endtask

   task automatic add_fixed(vec_req_type q, logic signed [31:0] rx, logic signed [31:0] ry,
         logic signed [31:0] rz, logic [30:0] len, bit eq, bit ovf, bit dz);
      vec_row_type row;
      row.req = q;
      row.fixed = 1'b1;
      row.rsp.r = '{rx, ry, rz};
      row.rsp.length = len;
      row.rsp.equal = eq;
      row.rsp.overflow = ovf;
      row.rsp.div_zero = dz;
      directed_rows.push_back(row);
   endtask

   task automatic build_table();
      localparam logic signed [31:0] ONE = 32'sh0001_0000;
      // all zeros in vadd: zero result, vectors equal
      add_fixed(mk_req(MODE_VADD, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 1, 0, 0);
      // positive and negative saturation on add and subtract
      add_fixed(mk_req(MODE_VADD, S_MAX, S_MIN, 1, 1, -1, 2, 0),
                S_MAX, S_MIN, 3, 0, 0, 1, 0);
      add_fixed(mk_req(MODE_SADD, S_MAX, 0, S_MIN, 0, 0, 0, S_MAX),
                S_MAX, S_MAX, -1, 0, 0, 1, 0);
      add_fixed(mk_req(MODE_VSUB, S_MIN, S_MAX, 5, 1, -1, 5, 0),
                S_MIN, S_MAX, 0, 0, 0, 1, 0);
      add_row(mk_req(MODE_SSUB, 7, -7, S_MIN, 0, 0, 0, S_MIN));
      add_row(mk_req(MODE_VMUL, ONE, -ONE, S_MAX, ONE, ONE, S_MAX, 0));
      add_row(mk_req(MODE_VMUL, -1, 1, S_MIN, 1, -1, S_MIN, 0));
      add_row(mk_req(MODE_SMUL, S_MIN, S_MAX, -3, 0, 0, 0, S_MIN));
      // divide by zero: sign of dividend picks the rail, zero dividend goes high
      add_fixed(mk_req(MODE_VDIV, 5, -5, 0, 0, 0, 0, 0), S_MAX, S_MIN, S_MAX, 0, 0, 0, 1);
      add_fixed(mk_req(MODE_SDIV, -1, 1, 0, 0, 0, 0, 0), S_MIN, S_MAX, S_MAX, 0, 0, 0, 1);
      add_row(mk_req(MODE_VDIV, S_MIN, S_MAX, ONE, -1, 1, 3, 0));
      add_row(mk_req(MODE_SDIV, S_MIN, S_MAX, 12345, 0, 0, 0, -ONE));
      add_fixed(mk_req(MODE_MAG, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 1, 0, 0);
      add_fixed(mk_req(MODE_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0), 0, 0, 0, 5 * ONE, 0, 0, 0);
      // magnitude beyond 31 bits saturates length
      add_fixed(mk_req(MODE_MAG, S_MIN, S_MIN, S_MIN, 0, 0, 0, 0),
                0, 0, 0, 31'h7fff_ffff, 0, 1, 0);
      add_row(mk_req(MODE_MAG, S_MAX, 0, 0, 0, 0, 0, 0));
      // normalizing a zero vector
      add_fixed(mk_req(MODE_NORM, 0, 0, 0, 1, 1, 1, 0),
                S_MAX, S_MAX, S_MAX, 0, 0, 0, 1);
      add_row(mk_req(MODE_NORM, 3 * ONE, -4 * ONE, 0, 0, 0, 0, 0));
      add_row(mk_req(MODE_NORM, S_MIN, S_MIN, S_MIN, 0, 0, 0, 0));
      add_row(mk_req(MODE_NORM, 1, 0, 0, 0, 0, 0, 0));
      add_fixed(mk_req(MODE_EQUAL, S_MIN, S_MAX, -1, S_MIN, S_MAX, -1, 0), 0, 0, 0, 0, 1, 0, 0);
      add_fixed(mk_req(MODE_EQUAL, 1, 2, 3, 1, 2, 4, 0), 0, 0, 0, 0, 0, 0, 0);
      // undefined modes only report equality
      add_fixed(mk_req(4'd11, 9, 9, 9, 9, 9, 9, 9), 0, 0, 0, 0, 1, 0, 0);
      add_fixed(mk_req(4'd15, -1, -1, -1, 0, 0, 0, -1), 0, 0, 0, 0, 0, 0, 0);
   endtask

   // ---------------------------------------------------------------------------
   // random requests: mostly defined modes, with mixed magnitudes
   // ---------------------------------------------------------------------------
   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? S_MAX : S_MIN;
         2: return $signed($urandom_range(0, 8)) - 4;
         3: return $signed($urandom() & 32'h000f_ffff) - 32'sh0008_0000;
         4: return 0;
         default: return $signed($urandom() & 32'h0fff_ffff) - 32'sh0800_0000;
      endcase
   endfunction

   function automatic vec_req_type rand_req();
      vec_req_type q;
      q.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                            : 4'($urandom_range(0, 10));
      for (int i = 0; i < 3; i++) q.a[i] = rand_word();
      for (int i = 0; i < 3; i++)
         q.b[i] = ($urandom_range(0, 5) == 0) ? q.a[i] : rand_word();
      q.scale = rand_word();
      return q;
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------
   // valid stays high after a transfer and drops only when a gap follows
   task automatic send_req(vec_req_type q);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 2) == 0) gap = 0;   // runs of back-to-back transfers
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= q.mode;
      req_a_x <= q.a[0]; req_a_y <= q.a[1]; req_a_z <= q.a[2];
      req_b_x <= q.b[0]; req_b_y <= q.b[1]; req_b_z <= q.b[2];
      req_scale <= q.scale;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      vec_row_type row;
      vec_req_type q;
      build_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         send_req(row.req);
         expected_results.push_back(row.fixed ? row.rsp : vector_result(row.req));
      end
      // sender pauses until the pipeline has drained
      req_valid <= 1'b0;
      wait (expected_results.size() == 0);
      @(posedge clock);
      for (int n = 0; n < N_RANDOM; n++) begin
         // long result stall while requests keep coming, so the block backs up
         if (n == 300) hold_rsp <= 1'b1;
         if (n == 1000) begin
            req_valid <= 1'b0;
            wait (expected_results.size() == 0);
            @(posedge clock);
         end
         q = rand_req();
         send_req(q);
         expected_results.push_back(vector_result(q));
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // ---------------------------------------------------------------------------
   // result side: random stalls plus one long hold-off
   // ---------------------------------------------------------------------------
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare each result transfer against the oldest expectation
   always @(posedge clock) begin
      vec_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected");
            mismatches++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_r_x !== e.r[0]) begin
               $error("r_x expected %0d actual %0d", e.r[0], rsp_r_x);
               mismatches++;
            end
            if (rsp_r_y !== e.r[1]) begin
               $error("r_y expected %0d actual %0d", e.r[1], rsp_r_y);
               mismatches++;
            end
            if (rsp_r_z !== e.r[2]) begin
               $error("r_z expected %0d actual %0d", e.r[2], rsp_r_z);
               mismatches++;
            end
            if (rsp_length !== e.length) begin
               $error("length expected %0d actual %0d", e.length, rsp_length);
               mismatches++;
            end
            if (rsp_equal !== e.equal) begin
               $error("equal expected %0b actual %0b", e.equal, rsp_equal);
               mismatches++;
            end
            if (rsp_overflow !== e.overflow) begin
               $error("overflow expected %0b actual %0b", e.overflow, rsp_overflow);
               mismatches++;
            end
            if (rsp_div_zero !== e.div_zero) begin
               $error("div_zero expected %0b actual %0b", e.div_zero, rsp_div_zero);
               mismatches++;
            end
         end
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // end of run: drain, let the pipeline settle, then report
   initial begin
      wait (stim_done);
      wait (expected_results.size() == 0);
      repeat (2 * LATENCY) @(posedge clock);
      if (expected_results.size() != 0) mismatches++;
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
